/* sv/nrsb_pkg.sv */
// Shared constants, types and helper functions of the RMC speed band parser.
package nrsb_pkg;

    localparam int unsigned MAX_LINE    = 200;
    localparam int unsigned SPEED_FIELD = 7;
    localparam int unsigned DATE_FIELD  = 9;
    localparam int unsigned TIME_FIELD  = 1;
    localparam int unsigned TAG_LEN     = 6;
    localparam int unsigned DATE_DIGITS = 6;
    localparam int unsigned TIME_DIGITS = 8;
    localparam int unsigned FRAC_MAX    = 3;

    localparam int POS_W      = 8;
    localparam int CNT_W      = 4;
    localparam int MK_W       = 20;
    localparam int KMH_W      = 21;
    localparam int BAND_W     = 21;
    localparam int DATE_W     = 24;
    localparam int TIME_W     = 32;
    localparam int DCNT_W     = 3;
    localparam int TCNT_W     = 4;
    localparam int FD_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int INT_W      = 25;
    localparam int FRAC_W     = 21;
    localparam int PROD_W     = 31;
    localparam int DIV_SHIFT  = 3;
    localparam int RECIP_W    = 29;
    localparam int RECIP_SHIFT = 35;
    localparam int QFULL_W    = 57;
    localparam int Q_W        = 22;

    localparam logic [MK_W-1:0]      MK_MAX         = 20'd1048575;
    localparam logic [KMH_W-1:0]     KMH_MAX        = 21'd2000000;
    localparam logic [10:0]          KNOT_SCALE     = 11'd1852;
    localparam logic [RECIP_W-1:0]   RECIP_125      = 29'd274877907;
    localparam logic [BAND_W-1:0]    BAND_LOW_RST   = 21'd39000;
    localparam logic [BAND_W-1:0]    BAND_HIGH_RST  = 21'd41000;
    localparam logic [CNT_W-1:0]     CNT_MAX        = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH  = 1'b1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              hdr;
        logic [CNT_W-1:0]  cc;
        logic [MK_W-1:0]   mk;
        logic [FD_W-1:0]   fd;
        logic              pt;
        logic              closed;
        logic              stop;
        logic [DATE_W-1:0] date;
        logic [DCNT_W-1:0] dc;
        logic [TIME_W-1:0] tim;
        logic [TCNT_W-1:0] tc;
        logic              ovf;
    } t_line;

    localparam t_line LINE_RST = '{
        pos: '0, hdr: 1'b1, cc: '0, mk: '0, fd: '0, pt: 1'b0, closed: 1'b0,
        stop: 1'b0, date: '0, dc: '0, tim: '0, tc: '0, ovf: 1'b0
    };

    typedef struct packed {
        logic              rmc;
        logic              spd_ok;
        logic [MK_W-1:0]   mk;
        logic              stamp;
        logic [DATE_W-1:0] date;
        logic [TIME_W-1:0] tim;
        logic              ovf;
    } t_snap;

    typedef struct packed {
        logic              is_rmc;
        logic              speed_valid;
        logic [KMH_W-1:0]  speed_milli_kmh;
        logic              led_left;
        logic              led_right;
        logic              stamp_valid;
        logic [DATE_W-1:0] date_bcd;
        logic [TIME_W-1:0] time_bcd;
        logic              line_overflow;
    } t_res;

    function automatic logic [7:0] rmc_tag(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h24;
            3'd1: ch = 8'h47;
            3'd2: ch = 8'h50;
            3'd3: ch = 8'h52;
            3'd4: ch = 8'h4D;
            3'd5: ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] frac_weight(input logic [FD_W-1:0] idx);
        logic [6:0] w;
        unique case (idx)
            2'd0: w = 7'd100;
            2'd1: w = 7'd10;
            2'd2: w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

endpackage

/* sv/nrsb_rx_if.sv */
// Byte input channel of the RMC speed band parser.
interface nrsb_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

/* sv/nrsb_res_if.sv */
// Line result channel of the RMC speed band parser.
interface nrsb_res_if;
    import nrsb_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_rmc;
    logic              speed_valid;
    logic [KMH_W-1:0]  speed_milli_kmh;
    logic              led_left;
    logic              led_right;
    logic              stamp_valid;
    logic [DATE_W-1:0] date_bcd;
    logic [TIME_W-1:0] time_bcd;
    logic              line_overflow;

    modport source(
        output valid, output is_rmc, output speed_valid, output speed_milli_kmh,
        output led_left, output led_right, output stamp_valid, output date_bcd,
        output time_bcd, output line_overflow, input ready
    );
    modport sink(
        input valid, input is_rmc, input speed_valid, input speed_milli_kmh,
        input led_left, input led_right, input stamp_valid, input date_bcd,
        input time_bcd, input line_overflow, output ready
    );
endinterface

/* sv/nmea_rmc_speed_band_parser_core.sv */
// Top level of the RMC speed band parser: line scanner, speed conversion and result register.
// The block takes one byte per clock cycle and keeps the field state of the current line
// in registers that update as each byte arrives. A newline byte yields one line result,
// offered on the result channel after stage registers s1, s2 and s3; the speed
// conversion runs through two multiplications (by 1852, registered, then by a reciprocal
// of 125 after a shift by three, registered) before the band compare and the result
// register. Input ready falls only while the result register holds a transaction that
// the sink has not taken, and then the whole pipeline holds.
module nmea_rmc_speed_band_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nrsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nrsb_pkg::BAND_W-1:0]       i_cfg_data,
    nrsb_rx_if.sink                           i_rx,
    nrsb_res_if.source                        o_res
);
    import nrsb_pkg::*;

    logic [BAND_W-1:0] r_band_low;
    logic [BAND_W-1:0] r_band_high;

    t_line r_line, n_line;
    logic  r_stamp_done;
    logic  r_left, r_right;
    logic  n_left, n_right;

    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_snap r_s1, r_s2, r_s3;
    t_snap n_snap;
    logic [PROD_W-1:0] r_s2_prod;
    logic [Q_W-1:0]    r_s3_q;
    t_res  r_res;

    logic w_adv, w_fire, w_nl, w_dig;
    logic [7:0] w_c;
    logic [3:0] w_d;
    logic [INT_W-1:0]  w_int;
    logic [FRAC_W-1:0] w_frac;
    logic w_rmc, w_decode;
    logic [QFULL_W-1:0] w_qfull;
    logic [KMH_W-1:0]   w_kmh;

    assign w_adv      = !r_out_valid || o_res.ready;
    assign i_rx.ready = w_adv;
    assign w_fire     = i_rx.valid && w_adv;
    assign w_c        = i_rx.rx_byte;
    assign w_nl       = (w_c == CH_NL);
    assign w_dig      = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_d        = w_c[3:0];

    assign w_int  = INT_W'(r_line.mk) * INT_W'(10) + INT_W'(w_d) * INT_W'(1000);
    assign w_frac = FRAC_W'(r_line.mk) + FRAC_W'(frac_weight(r_line.fd)) * FRAC_W'(w_d);

    assign w_rmc    = r_line.hdr && (r_line.pos >= POS_W'(TAG_LEN));
    assign w_decode = w_rmc && !r_line.ovf;

    always_comb begin
        n_snap        = '0;
        n_snap.rmc    = w_rmc;
        n_snap.ovf    = r_line.ovf;
        n_snap.spd_ok = w_decode && r_line.closed;
        n_snap.mk     = r_line.mk;
        n_snap.stamp  = w_decode && !r_stamp_done
                        && (r_line.dc == DCNT_W'(DATE_DIGITS))
                        && (r_line.tc == TCNT_W'(TIME_DIGITS))
                        && (r_line.cc > CNT_W'(DATE_FIELD))
                        && (r_line.cc > CNT_W'(TIME_FIELD));
        if (n_snap.stamp) begin
            n_snap.date = r_line.date;
            n_snap.tim  = r_line.tim;
        end
    end

    always_comb begin
        n_line = r_line;
        if (w_fire) begin
            if (w_nl) begin
                n_line = LINE_RST;
            end else if (r_line.pos < POS_W'(MAX_LINE - 1)) begin
                if (r_line.pos < POS_W'(TAG_LEN) && w_c != rmc_tag(r_line.pos[2:0])) begin
                    n_line.hdr = 1'b0;
                end
                if (w_c == CH_COMMA) begin
                    if (r_line.cc == CNT_W'(SPEED_FIELD)) begin
                        n_line.closed = 1'b1;
                    end
                    if (r_line.cc != CNT_MAX) begin
                        n_line.cc = r_line.cc + 1'b1;
                    end
                end else begin
                    if (r_line.cc == CNT_W'(SPEED_FIELD) && !r_line.closed && !r_line.stop) begin
                        if (w_dig) begin
                            if (!r_line.pt) begin
                                n_line.mk = (w_int > INT_W'(MK_MAX)) ? MK_MAX : w_int[MK_W-1:0];
                            end else if (r_line.fd < FD_W'(FRAC_MAX)) begin
                                n_line.mk = (w_frac > FRAC_W'(MK_MAX)) ? MK_MAX
                                                                      : w_frac[MK_W-1:0];
                                n_line.fd = r_line.fd + 1'b1;
                            end
                        end else if (w_c == CH_POINT && !r_line.pt) begin
                            n_line.pt = 1'b1;
                        end else begin
                            n_line.stop = 1'b1;
                        end
                    end
                    if (r_line.cc == CNT_W'(DATE_FIELD) && w_dig
                        && r_line.dc < DCNT_W'(DATE_DIGITS)) begin
                        n_line.date = {r_line.date[DATE_W-5:0], w_d};
                        n_line.dc   = r_line.dc + 1'b1;
                    end
                    if (r_line.cc == CNT_W'(TIME_FIELD) && w_dig
                        && r_line.tc < TCNT_W'(TIME_DIGITS)) begin
                        n_line.tim = {r_line.tim[TIME_W-5:0], w_d};
                        n_line.tc  = r_line.tc + 1'b1;
                    end
                end
                n_line.pos = r_line.pos + 1'b1;
            end else begin
                n_line.ovf = 1'b1;
            end
        end
    end

    assign w_qfull = QFULL_W'(r_s2_prod[PROD_W-1:DIV_SHIFT]) * QFULL_W'(RECIP_125);
    assign w_kmh   = (r_s3_q > Q_W'(KMH_MAX)) ? KMH_MAX : r_s3_q[KMH_W-1:0];

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        if (r_s3.spd_ok) begin
            if (w_kmh >= r_band_low && w_kmh <= r_band_high) begin
                n_left  = 1'b1;
                n_right = 1'b0;
            end else if (w_kmh > r_band_high) begin
                n_left  = 1'b1;
                n_right = 1'b1;
            end else begin
                n_left  = 1'b0;
                n_right = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low  <= BAND_LOW_RST;
            r_band_high <= BAND_HIGH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BAND_LOW) begin
                r_band_low <= i_cfg_data;
            end else begin
                r_band_high <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= LINE_RST;
            r_stamp_done <= 1'b0;
            r_left       <= 1'b0;
            r_right      <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_line <= n_line;
            if (w_fire && w_nl && n_snap.stamp) begin
                r_stamp_done <= 1'b1;
            end
            if (w_adv) begin
                r_s1_valid  <= w_fire && w_nl;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_out_valid <= r_s3_valid;
                if (r_s3_valid) begin
                    r_left  <= n_left;
                    r_right <= n_right;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1      <= n_snap;
            r_s2      <= r_s1;
            r_s2_prod <= PROD_W'(r_s1.mk) * PROD_W'(KNOT_SCALE);
            r_s3      <= r_s2;
            r_s3_q    <= w_qfull[QFULL_W-1:RECIP_SHIFT];
            r_res.is_rmc          <= r_s3.rmc;
            r_res.speed_valid     <= r_s3.spd_ok;
            r_res.speed_milli_kmh <= r_s3.spd_ok ? w_kmh : '0;
            r_res.led_left        <= n_left;
            r_res.led_right       <= n_right;
            r_res.stamp_valid     <= r_s3.stamp;
            r_res.date_bcd        <= r_s3.date;
            r_res.time_bcd        <= r_s3.tim;
            r_res.line_overflow   <= r_s3.ovf;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.is_rmc          = r_res.is_rmc;
    assign o_res.speed_valid     = r_res.speed_valid;
    assign o_res.speed_milli_kmh = r_res.speed_milli_kmh;
    assign o_res.led_left        = r_res.led_left;
    assign o_res.led_right       = r_res.led_right;
    assign o_res.stamp_valid     = r_res.stamp_valid;
    assign o_res.date_bcd        = r_res.date_bcd;
    assign o_res.time_bcd        = r_res.time_bcd;
    assign o_res.line_overflow   = r_res.line_overflow;

    a_right_needs_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.led_right |-> o_res.led_left)
        else $error("Right indicator is on while the left one is off.");

    a_stamp_needs_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.stamp_valid |-> o_res.is_rmc && !o_res.line_overflow)
        else $error("Stamp reported on a line that was not decoded.");

    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.speed_valid |-> o_res.speed_milli_kmh == '0)
        else $error("Speed is nonzero without a valid speed field.");

    a_stamp_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stamp_done |=> r_stamp_done)
        else $error("Stamp capture flag was cleared.");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line.pos <= POS_W'(MAX_LINE - 1))
        else $error("Line position ran past the maximum line length.");

endmodule
